[hdl/abrb_pkg.sv]
package abrb_pkg;

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned FbAddrMaxW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDestX      = 3'd0,
    CfgDestY      = 3'd1,
    CfgRectWidth  = 3'd2,
    CfgRectHeight = 3'd3,
    CfgSrcLeft    = 3'd4,
    CfgSrcTop     = 3'd5,
    CfgSrcStride  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0]  dest_x;
    logic [8:0]  dest_y;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [11:0] src_left;
    logic [11:0] src_top;
    logic [12:0] src_stride;
  } cfg_t;

  typedef struct packed {
    logic [FbAddrMaxW-1:0] fb_addr;
    logic [17:0]           dest_index;
    logic [23:0]           source_index;
    logic                  dropped;
    logic                  last;
    logic [31:0]           pixel;
  } item_t;

endpackage

[hdl/abrb_front.sv]
module abrb_front
  import abrb_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = 512,
  parameter int unsigned FB_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        cfg_we_i,
  input  logic        clearing_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] source_pixel_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  localparam int unsigned DidxW = $clog2(FB_WIDTH) + 14;
  localparam logic [DidxW-1:0] FbWords = DidxW'(FB_WIDTH * FB_HEIGHT);
  localparam logic [DidxW-1:0] RowStep = DidxW'(FB_WIDTH);

  logic [9:0]       col_q, row_q;
  logic [DidxW-1:0] drow_q, dprod_q;
  logic [23:0]      srow_q, sprod_q;
  logic [1:0]       settle_q;

  logic [DidxW-1:0] didx, d_base;
  logic [23:0]      sidx, s_base;
  logic             row_end, last, drop, accept;

  function automatic logic [31:0] swizzle(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  always_comb begin
    didx    = drow_q + DidxW'(col_q);
    sidx    = srow_q + 24'(col_q);
    d_base  = dprod_q + DidxW'(cfg_i.dest_x);
    s_base  = sprod_q + 24'(cfg_i.src_left);
    row_end = (11'(col_q) + 11'd1) >= 11'(cfg_i.rect_width);
    last    = row_end && ((11'(row_q) + 11'd1) >= 11'(cfg_i.rect_height));
    drop    = didx >= FbWords;
  end

  assign in_stall_o = clearing_i || (settle_q != 2'd0) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = accept;

  always_comb begin
    q_item_o.fb_addr      = FbAddrMaxW'(didx);
    q_item_o.dest_index   = didx[17:0];
    q_item_o.source_index = sidx;
    q_item_o.dropped      = drop;
    q_item_o.last         = last;
    q_item_o.pixel        = swizzle(source_pixel_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dprod_q <= '0;
      sprod_q <= '0;
    end else begin
      dprod_q <= DidxW'(cfg_i.dest_y) * RowStep;
      sprod_q <= 24'(cfg_i.src_top) * 24'(cfg_i.src_stride);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      drow_q   <= '0;
      srow_q   <= '0;
      settle_q <= '0;
    end else if (cfg_we_i) begin
      col_q    <= '0;
      row_q    <= '0;
      settle_q <= 2'd2;
    end else begin
      if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      if (settle_q == 2'd1) begin
        drow_q <= d_base;
        srow_q <= s_base;
      end else if (accept) begin
        if (row_end) begin
          col_q <= '0;
          if (last) begin
            row_q  <= '0;
            drow_q <= d_base;
            srow_q <= s_base;
          end else begin
            row_q  <= row_q + 10'd1;
            drow_q <= drow_q + RowStep;
            srow_q <= srow_q + 24'(cfg_i.src_stride);
          end
        end else begin
          col_q <= col_q + 10'd1;
        end
      end
    end
  end

endmodule

[hdl/abrb_queue.sv]
module abrb_queue
  import abrb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  item_t            slot_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (QPtrW + 1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/abrb_back.sv]
module abrb_back
  import abrb_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = 512,
  parameter int unsigned FB_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  item_t       q_head_i,
  output logic        q_pop_o,
  output logic        clearing_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [17:0] dest_index_o,
  output logic [31:0] written_pixel_o,
  output logic [23:0] source_index_o,
  output logic        dropped_o,
  output logic        last_o
);

  localparam int unsigned FbWords = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned AddrW   = $clog2(FbWords);

  logic [31:0]      mem [FbWords];
  logic [31:0]      rd_q;

  logic             clearing_q;
  logic [AddrW-1:0] clr_q;

  logic             b1_v_q, b2_v_q;
  item_t            b1_q, b2_q;
  logic [31:0]      b2_d_q;
  logic signed [17:0] prod_q [4];
  logic signed [17:0] prod_d [4];

  logic             wr_v_q;
  logic [AddrW-1:0] wr_addr_q;
  logic [31:0]      wr_data_q;

  logic             out_v_q;
  logic [17:0]      out_didx_q;
  logic [31:0]      out_pix_q;
  logic [23:0]      out_sidx_q;
  logic             out_drop_q, out_last_q;

  logic             adv, hazard, issue, mem_we;
  logic [AddrW-1:0] head_addr, b1_addr, b2_addr;
  logic [31:0]      d_word, wr_word;

  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [16:0] t;
    t = 17'(m) + 17'(m[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  assign head_addr = q_head_i.fb_addr[AddrW-1:0];
  assign b1_addr   = b1_q.fb_addr[AddrW-1:0];
  assign b2_addr   = b2_q.fb_addr[AddrW-1:0];

  assign adv    = !out_v_q || !out_stall_i;
  assign hazard = b1_v_q && !b1_q.dropped && !q_head_i.dropped && (b1_addr == head_addr);
  assign issue  = adv && !q_empty_i && !clearing_q && !hazard;
  assign mem_we = adv && b2_v_q && !b2_q.dropped;

  assign q_pop_o    = issue;
  assign clearing_o = clearing_q;

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= '0;
    end else if (mem_we) begin
      mem[b2_addr] <= wr_word;
    end
    if (adv) begin
      rd_q <= mem[head_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      if (clr_q == AddrW'(FbWords - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    logic [8:0] diff;
    logic [7:0] s, d;
    d_word = (wr_v_q && (wr_addr_q == b1_addr)) ? wr_data_q : rd_q;
    for (int c = 0; c < 4; c++) begin
      s         = b1_q.pixel[8*c +: 8];
      d         = d_word[8*c +: 8];
      diff      = {1'b0, s} - {1'b0, d};
      prod_d[c] = $signed(diff) * $signed({1'b0, b1_q.pixel[31:24]});
    end
  end

  always_comb begin
    logic        neg;
    logic [17:0] mag;
    logic [7:0]  q, d;
    wr_word = '0;
    for (int c = 0; c < 4; c++) begin
      neg = prod_q[c][17];
      mag = neg ? 18'(-prod_q[c]) : 18'(prod_q[c]);
      q   = div255(mag[15:0]);
      d   = b2_d_q[8*c +: 8];
      wr_word[8*c +: 8] = neg ? (d - q) : (d + q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      wr_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q  <= issue;
      b2_v_q  <= b1_v_q;
      wr_v_q  <= mem_we;
      out_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q       <= q_head_i;
      b2_q       <= b1_q;
      b2_d_q     <= d_word;
      for (int c = 0; c < 4; c++) begin
        prod_q[c] <= prod_d[c];
      end
      wr_addr_q  <= b2_addr;
      wr_data_q  <= wr_word;
      out_didx_q <= b2_q.dest_index;
      out_pix_q  <= b2_q.dropped ? 32'd0 : wr_word;
      out_sidx_q <= b2_q.source_index;
      out_drop_q <= b2_q.dropped;
      out_last_q <= b2_q.last;
    end
  end

  assign out_valid_o     = out_v_q;
  assign dest_index_o    = out_didx_q;
  assign written_pixel_o = out_pix_q;
  assign source_index_o  = out_sidx_q;
  assign dropped_o       = out_drop_q;
  assign last_o          = out_last_q;

  a_clear_empty_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!b1_v_q && !b2_v_q && !out_v_q))
    else $error("pipeline busy during framebuffer clear");

  a_no_adjacent_alias : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_v_q && b2_v_q && !b1_q.dropped && !b2_q.dropped) |-> (b1_addr != b2_addr))
    else $error("adjacent stages hold the same framebuffer word");

  a_drop_zero_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_drop_q) |-> (out_pix_q == 32'd0))
    else $error("dropped transaction carries a pixel");

  a_clear_full_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_q) == AddrW'(FbWords - 1)))
    else $error("framebuffer clear ended early");

endmodule

[hdl/alpha_blend_rect_blitter.sv]
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   source_pixel_i
// out       source     out_valid_o / out_stall_i dest_index_o, written_pixel_o,
//                                                source_index_o, dropped_o, last_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle unless stalled; items pass queue, b1, b2 and output register.
// After reset the framebuffer is cleared, word by word, with the input stalled.
// Each register write stalls the input while the row bases are recomputed.
// A pixel hitting the same framebuffer word as the pixel just before is held back in the queue
// until that pixel has left the first blend stage.
// An output stall freezes the blend pipeline; the four-entry queue accepts input until full.
module alpha_blend_rect_blitter
  import abrb_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = 512,
  parameter int unsigned FB_HEIGHT = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         source_pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [17:0]         dest_index_o,
  output logic [31:0]         written_pixel_o,
  output logic [23:0]         source_index_o,
  output logic                dropped_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  logic  cfg_we;
  logic  clearing;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d  = cfg_q;
    cfg_we = cfg_valid_i;
    case (cfg_idx_e'(cfg_index_i))
      CfgDestX:      cfg_d.dest_x      = cfg_data_i[8:0];
      CfgDestY:      cfg_d.dest_y      = cfg_data_i[8:0];
      CfgRectWidth:  cfg_d.rect_width  = cfg_data_i[9:0];
      CfgRectHeight: cfg_d.rect_height = cfg_data_i[9:0];
      CfgSrcLeft:    cfg_d.src_left    = cfg_data_i[11:0];
      CfgSrcTop:     cfg_d.src_top     = cfg_data_i[11:0];
      CfgSrcStride:  cfg_d.src_stride  = cfg_data_i[12:0];
      default:       cfg_we            = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x      <= 9'd0;
      cfg_q.dest_y      <= 9'd0;
      cfg_q.rect_width  <= 10'd1;
      cfg_q.rect_height <= 10'd1;
      cfg_q.src_left    <= 12'd0;
      cfg_q.src_top     <= 12'd0;
      cfg_q.src_stride  <= 13'd1;
    end else if (cfg_we) begin
      cfg_q <= cfg_d;
    end
  end

  abrb_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cfg_we_i       (cfg_we),
    .clearing_i     (clearing),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_pixel_i (source_pixel_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  abrb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  abrb_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .dest_index_o    (dest_index_o),
    .written_pixel_o (written_pixel_o),
    .source_index_o  (source_index_o),
    .dropped_o       (dropped_o),
    .last_o          (last_o)
  );

endmodule
